// ----- design/chained_hash_table_engine_unit_defines.svh -----
// Assertion macros
`ifndef CHAINED_HASH_TABLE_ENGINE_UNIT_DEFINES_SVH
`define CHAINED_HASH_TABLE_ENGINE_UNIT_DEFINES_SVH
`define CHT_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define CHT_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- design/cht_pkg.sv -----
package cht_pkg;
    localparam int BUCKETS_DEF    = 256;
    localparam int POOL_SIZE_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int KEY_BITS       = 31;
    localparam int FOLD_SHIFT     = 15;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    function automatic logic [KEY_BITS-1:0] fold_key(input logic [31:0] raw);
        fold_key = {15'd0, raw[15:0]} + {1'b0, raw[31:17], 15'd0};
    endfunction
endpackage

// ----- design/cht_front.sv -----
module cht_front #(
    parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF,
    parameter int DEPTH      = 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_op,
    input  logic [31:0]                  s_raw_key,
    input  logic [31:0]                  s_value_in,
    output logic                         q_valid,
    input  logic                         q_ready,
    output logic [1:0]                   q_op,
    output logic [cht_pkg::KEY_BITS-1:0] q_key,
    output logic [VALUE_BITS-1:0]        q_val
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W  = 2 + cht_pkg::KEY_BITS + VALUE_BITS;

    logic [W-1:0]  fifo_mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          push, pop;

    assign s_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;
    assign {q_op, q_key, q_val} = fifo_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)  rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + AW'(1);
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= {s_op, cht_pkg::fold_key(s_raw_key),
                                     s_value_in[VALUE_BITS-1:0]};
        end
    end
endmodule

// ----- design/cht_back.sv -----
`include "chained_hash_table_engine_unit_defines.svh"
module cht_back #(
    parameter int BUCKETS    = cht_pkg::BUCKETS_DEF,
    parameter int POOL_SIZE  = cht_pkg::POOL_SIZE_DEF,
    parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  logic [1:0]                   q_op,
    input  logic [cht_pkg::KEY_BITS-1:0] q_key,
    input  logic [VALUE_BITS-1:0]        q_val,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [31:0]                  m_value_out
);
    localparam int HW = $clog2(POOL_SIZE + 1);
    localparam int EW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [HW-1:0] NIL = HW'(POOL_SIZE);
    localparam int KB = cht_pkg::KEY_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_HEAD, S_HEADW, S_RD, S_RDW, S_EVAL, S_CLR, S_DONE
    } state_t;

    // pool memories
    logic [KB-1:0]         key_mem  [POOL_SIZE];
    logic [VALUE_BITS-1:0] val_mem  [POOL_SIZE];
    logic                  vld_mem  [POOL_SIZE];
    logic [HW-1:0]         next_mem [POOL_SIZE];
    logic [HW-1:0]         head_mem [BUCKETS];
    // per-bucket valid marks emulate the clear of heads
    logic [BUCKETS-1:0]    head_ok_reg;

    state_t                state_reg;
    logic [1:0]            op_reg;
    logic [KB-1:0]         key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [BW-1:0]         bkt_reg;
    logic [HW-1:0]         cur_reg, fill_reg;
    logic [HW:0]           steps_reg;
    logic [1:0]            st_reg;
    logic [31:0]           vout_reg;
    logic                  out_v_reg;
    logic [1:0]            out_st_reg;
    logic [31:0]           out_vout_reg;

    logic [HW-1:0]         head_rd_reg;
    logic [KB-1:0]         k_rd_reg;
    logic [VALUE_BITS-1:0] v_rd_reg;
    logic                  vl_rd_reg;
    logic [HW-1:0]         n_rd_reg;

    // write ports
    logic                  e_we, nx_we, vl_we, h_we;
    logic [EW-1:0]         e_wa, nx_wa, vl_wa;
    logic                  vl_wd;
    logic [HW-1:0]         nx_wd;

    // link of a fresh tail needs a second write to next_mem
    logic link_reg;

    assign q_ready     = (state_reg == S_IDLE);
    assign m_valid     = out_v_reg;
    assign m_status    = out_st_reg;
    assign m_value_out = out_vout_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == S_HEAD) head_rd_reg <= head_mem[bkt_reg];
        if (state_reg == S_RD) begin
            k_rd_reg  <= key_mem[cur_reg[EW-1:0]];
            v_rd_reg  <= val_mem[cur_reg[EW-1:0]];
            vl_rd_reg <= vld_mem[cur_reg[EW-1:0]];
            n_rd_reg  <= next_mem[cur_reg[EW-1:0]];
        end
        if (e_we) begin
            key_mem[e_wa] <= key_reg;
            val_mem[e_wa] <= val_reg;
        end
        if (vl_we) vld_mem[vl_wa] <= vl_wd;
        if (nx_we) next_mem[nx_wa] <= nx_wd;
        if (h_we) head_mem[bkt_reg] <= fill_reg;
    end

    logic is_ins, nxt_live, kmatch, fill_full, head_live;
    assign is_ins    = (op_reg == cht_pkg::OP_INSERT);
    assign nxt_live  = (n_rd_reg < NIL) &&
                       (steps_reg + (HW+1)'(1) < (HW+1)'(POOL_SIZE));
    assign kmatch    = vl_rd_reg && (k_rd_reg == key_reg);
    assign fill_full = (fill_reg >= NIL);
    assign head_live = head_ok_reg[bkt_reg] && (head_rd_reg < NIL);

    always_comb begin
        e_we = 1'b0; e_wa = cur_reg[EW-1:0];
        vl_we = 1'b0; vl_wa = cur_reg[EW-1:0]; vl_wd = 1'b1;
        nx_we = 1'b0; nx_wa = cur_reg[EW-1:0]; nx_wd = NIL;
        h_we = 1'b0;
        if (state_reg == S_HEADW && !head_live && is_ins && !fill_full) begin
            h_we = 1'b1;
            e_we = 1'b1; e_wa = fill_reg[EW-1:0];
            vl_we = 1'b1; vl_wa = fill_reg[EW-1:0];
            nx_we = 1'b1; nx_wa = fill_reg[EW-1:0];
        end else if (state_reg == S_EVAL) begin
            if (is_ins) begin
                if (nxt_live && !vl_rd_reg) begin
                    e_we = 1'b1; vl_we = 1'b1;
                end else if (!nxt_live && !kmatch && !fill_full) begin
                    e_we = 1'b1; e_wa = fill_reg[EW-1:0];
                    vl_we = 1'b1; vl_wa = fill_reg[EW-1:0];
                    nx_we = 1'b1; nx_wa = fill_reg[EW-1:0];
                end
            end else if (op_reg == cht_pkg::OP_REMOVE && kmatch) begin
                vl_we = 1'b1; vl_wd = 1'b0;
            end
        end else if (state_reg == S_CLR && link_reg) begin
            nx_we = 1'b1;
            nx_wd = fill_reg - HW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            out_v_reg    <= 1'b0;
            out_st_reg   <= cht_pkg::ST_OK;
            out_vout_reg <= '0;
            fill_reg     <= '0;
            head_ok_reg  <= '0;
            link_reg     <= 1'b0;
        end else begin
            if (state_reg == S_DONE && (!out_v_reg || m_ready)) out_v_reg <= 1'b1;
            else if (m_ready) out_v_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        op_reg    <= q_op;
                        key_reg   <= q_key;
                        val_reg   <= q_val;
                        bkt_reg   <= BW'(q_key % BUCKETS);
                        steps_reg <= '0;
                        st_reg    <= cht_pkg::ST_OK;
                        vout_reg  <= '0;
                        state_reg <= (q_op == cht_pkg::OP_CLEAR) ? S_CLR : S_HEAD;
                    end
                end
                S_HEAD: state_reg <= S_HEADW;
                S_HEADW: begin
                    if (head_live) begin
                        cur_reg   <= head_rd_reg;
                        state_reg <= S_RD;
                    end else begin
                        if (!is_ins) st_reg <= cht_pkg::ST_MISS;
                        else if (fill_full) st_reg <= cht_pkg::ST_FULL;
                        else begin
                            fill_reg <= fill_reg + HW'(1);
                            head_ok_reg[bkt_reg] <= 1'b1;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_RD: state_reg <= S_RDW;
                S_RDW: state_reg <= S_EVAL;
                S_EVAL: begin
                    if (is_ins) begin
                        if (kmatch) begin
                            st_reg    <= cht_pkg::ST_MISS;
                            state_reg <= S_DONE;
                        end else if (nxt_live && vl_rd_reg) begin
                            cur_reg   <= n_rd_reg;
                            steps_reg <= steps_reg + (HW+1)'(1);
                            state_reg <= S_RD;
                        end else if (nxt_live) begin
                            // removed entry taken over
                            state_reg <= S_DONE;
                        end else if (fill_full) begin
                            st_reg    <= cht_pkg::ST_FULL;
                            state_reg <= S_DONE;
                        end else begin
                            fill_reg  <= fill_reg + HW'(1);
                            link_reg  <= 1'b1;
                            state_reg <= S_CLR;
                        end
                    end else if (kmatch) begin
                        if (op_reg == cht_pkg::OP_LOOKUP) vout_reg <= 32'(v_rd_reg);
                        state_reg <= S_DONE;
                    end else if (nxt_live) begin
                        cur_reg   <= n_rd_reg;
                        steps_reg <= steps_reg + (HW+1)'(1);
                        state_reg <= S_RD;
                    end else begin
                        st_reg    <= cht_pkg::ST_MISS;
                        state_reg <= S_DONE;
                    end
                end
                S_CLR: begin
                    // clear op, or link-in of a new tail
                    if (link_reg) link_reg <= 1'b0;
                    else begin
                        head_ok_reg <= '0;
                        fill_reg    <= '0;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!out_v_reg || m_ready) begin
                        out_st_reg   <= st_reg;
                        out_vout_reg <= vout_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `CHT_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= NIL)
    `CHT_ASSERT_IMP(a_ready_idle, aclk, aresetn, q_ready, !link_reg)
    `CHT_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status))
    `CHT_ASSERT_NXT(a_out_hold_val, aclk, aresetn, m_valid && !m_ready, $stable(m_value_out))
endmodule

// ----- design/chained_hash_table_engine_unit.sv -----
// Channel  | Direction | Ports
// input    | in        | s_valid s_ready s_op s_raw_key s_value_in
// result   | out       | m_valid m_ready m_status m_value_out
// With an idle back end the result follows the input through the queue, the head
// read, a read per chain entry and a link step when an insert adds a new tail.
// A clear skips the reads. The back end takes a new item only when idle.
// A held result stalls the back end only when the next one is ready; the two-entry
// queue keeps s_ready high until it fills. Reset is synchronous, active low.
module chained_hash_table_engine_unit #(
    parameter int BUCKETS    = cht_pkg::BUCKETS_DEF,
    parameter int POOL_SIZE  = cht_pkg::POOL_SIZE_DEF,
    parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [31:0] s_raw_key,
    input  logic [31:0] s_value_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_value_out
);
    logic                         q_valid, q_ready;
    logic [1:0]                   q_op;
    logic [cht_pkg::KEY_BITS-1:0] q_key;
    logic [VALUE_BITS-1:0]        q_val;

    cht_front #(.VALUE_BITS(VALUE_BITS), .DEPTH(2)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_op, .s_raw_key, .s_value_in,
        .q_valid, .q_ready, .q_op, .q_key, .q_val
    );

    cht_back #(.BUCKETS(BUCKETS), .POOL_SIZE(POOL_SIZE), .VALUE_BITS(VALUE_BITS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_op, .q_key, .q_val,
        .m_valid, .m_ready, .m_status, .m_value_out
    );
endmodule
